// File: src/swtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtt_pkg
// Shared codes for the software timer table: actions, event kinds and the
// per-tick report limit.
// ----------------------------------------------------------------------------
package swtt_pkg;

    typedef logic [1:0] t_action;
    typedef logic [1:0] t_event_kind;

    localparam t_action ACT_ONESHOT  = 2'd0;
    localparam t_action ACT_PERIODIC = 2'd1;
    localparam t_action ACT_CANCEL   = 2'd2;
    localparam t_action ACT_TICK     = 2'd3;

    localparam t_event_kind EV_ASSIGNED = 2'd0;
    localparam t_event_kind EV_FIRED    = 2'd1;
    localparam t_event_kind EV_FULL     = 2'd2;

    // At most this many fires are reported for one tick.
    localparam int MAX_REPORT   = 16;
    localparam int REPORT_CNT_W = $clog2(MAX_REPORT + 1);

endpackage

// File: src/software_timer_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_table_top
// Table of one-shot and periodic timers advanced by tick items; the counts
// live in a one-port-read, one-port-write synchronous memory.
// ----------------------------------------------------------------------------
// A cancel item is taken at once and leaves busy low. A start item searches
// the active bits one slot per cycle from slot 0, so it keeps busy high
// until it reaches the first free slot (or the last slot when the table is
// full); a periodic start then passes through S_ASSIGN for its second event.
// A tick item keeps busy high while the count memory is read one slot per
// cycle and each slot is updated in the cycle after its read, then the
// S_FLUSH state delivers the final fire, if any. Results appear on o_strobe,
// at most one per cycle, and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module software_timer_table_top #(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_slot,
    input  logic [23:0] i_period,
    output logic        o_strobe,
    output logic [1:0]  o_event_kind,
    output logic [3:0]  o_slot_index,
    output logic        o_last
);

    localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int XW = SW + 4;
    localparam int CW = COUNT_WIDTH;
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_TIMERS - 1);
    localparam logic [32:0] CMAX = (33'd1 << CW) - 33'd1;
    localparam int RW = swtt_pkg::REPORT_CNT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_ASSIGN = 3'd2;
    localparam logic [2:0] S_TICK   = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    function automatic logic [3:0] low4(input logic [SW-1:0] v);
        logic [XW-1:0] t;
        t = XW'(v);
        return t[3:0];
    endfunction

    // Control state.
    logic [2:0]            r_state, n_state;
    logic [NUM_TIMERS-1:0] r_active, n_active;
    logic [NUM_TIMERS-1:0] r_periodic, n_periodic;
    logic [SW-1:0]         r_idx, n_idx;
    logic                  r_issue_done, n_issue_done;
    logic                  r_p_vld, n_p_vld;
    logic                  r_pend_vld, n_pend_vld;
    logic [RW-1:0]         r_nfire, n_nfire;
    logic                  r_out_vld, n_out_vld;

    // Payload.
    logic                  r_repeat, n_repeat;
    logic [CW-1:0]         r_period, n_period;
    logic [SW-1:0]         r_p_idx, n_p_idx;
    logic [SW-1:0]         r_pend_idx, n_pend_idx;
    swtt_pkg::t_event_kind r_kind, n_kind;
    logic [3:0]            r_sidx, n_sidx;
    logic                  r_last, n_last;

    // Count memory: {reload_value, ticks_left} per slot.
    logic [2*CW-1:0] mem [NUM_TIMERS];
    logic [2*CW-1:0] r_rdata;
    logic            w_we;
    logic [SW-1:0]   w_waddr;
    logic [2*CW-1:0] w_wdata;

    logic [32:0]     w_per_ext;
    logic [CW-1:0]   w_per_sat;
    logic [XW-1:0]   w_cslot;
    logic [CW-1:0]   w_cur_ticks;
    logic [CW-1:0]   w_cur_reload;
    logic            w_hit;
    logic            w_fire;

    assign w_per_ext    = 33'(i_period);
    assign w_per_sat    = (w_per_ext > CMAX) ? CMAX[CW-1:0] : w_per_ext[CW-1:0];
    assign w_cslot      = XW'(i_slot);
    assign w_cur_ticks  = r_rdata[CW-1:0];
    assign w_cur_reload = r_rdata[2*CW-1:CW];
    assign w_hit        = r_p_vld && r_active[r_p_idx];
    assign w_fire       = w_hit && (w_cur_ticks <= CW'(1));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[r_idx];
    end

    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_periodic   = r_periodic;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_p_vld      = r_p_vld;
        n_pend_vld   = r_pend_vld;
        n_nfire      = r_nfire;
        n_out_vld    = 1'b0;
        n_repeat     = r_repeat;
        n_period     = r_period;
        n_p_idx      = r_p_idx;
        n_pend_idx   = r_pend_idx;
        n_kind       = r_kind;
        n_sidx       = r_sidx;
        n_last       = r_last;
        w_we         = 1'b0;
        w_waddr      = r_idx;
        w_wdata      = {r_period, r_period};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_action) inside
                        swtt_pkg::ACT_ONESHOT, swtt_pkg::ACT_PERIODIC: begin
                            n_repeat = (i_action == swtt_pkg::ACT_PERIODIC);
                            n_period = w_per_sat;
                            n_idx    = '0;
                            n_state  = S_FIND;
                        end
                        swtt_pkg::ACT_CANCEL: begin
                            if (32'(i_slot) < NUM_TIMERS) begin
                                n_active[w_cslot[SW-1:0]]   = 1'b0;
                                n_periodic[w_cslot[SW-1:0]] = 1'b0;
                            end
                        end
                        default: begin
                            n_idx        = '0;
                            n_issue_done = 1'b0;
                            n_p_vld      = 1'b0;
                            n_pend_vld   = 1'b0;
                            n_nfire      = '0;
                            n_state      = S_TICK;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (!r_active[r_idx]) begin
                    w_we                = 1'b1;
                    n_active[r_idx]     = 1'b1;
                    n_periodic[r_idx]   = r_repeat;
                    n_out_vld           = 1'b1;
                    n_sidx              = low4(r_idx);
                    if (r_repeat) begin
                        n_kind  = swtt_pkg::EV_FIRED;
                        n_last  = 1'b0;
                        n_state = S_ASSIGN;
                    end else begin
                        n_kind  = swtt_pkg::EV_ASSIGNED;
                        n_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (r_idx == LAST_SLOT) begin
                    n_out_vld = 1'b1;
                    n_kind    = swtt_pkg::EV_FULL;
                    n_sidx    = 4'd0;
                    n_last    = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            S_ASSIGN: begin
                n_out_vld = 1'b1;
                n_kind    = swtt_pkg::EV_ASSIGNED;
                n_sidx    = low4(r_idx);
                n_last    = 1'b1;
                n_state   = S_IDLE;
            end
            S_TICK: begin
                // Read stage: one slot address per cycle.
                if (!r_issue_done) begin
                    n_p_vld = 1'b1;
                    n_p_idx = r_idx;
                    if (r_idx == LAST_SLOT) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + SW'(1);
                    end
                end else begin
                    n_p_vld = 1'b0;
                end
                // Update stage: the slot read in the previous cycle. A fire is held
                // back until the next fire or the flush so that the final one can carry last.
                w_waddr = r_p_idx;
                if (w_hit) begin
                    if (w_fire) begin
                        if (r_periodic[r_p_idx]) begin
                            w_we    = 1'b1;
                            w_wdata = {w_cur_reload, w_cur_reload};
                        end else begin
                            n_active[r_p_idx] = 1'b0;
                        end
                        if (r_nfire < RW'(swtt_pkg::MAX_REPORT)) begin
                            if (r_pend_vld) begin
                                n_out_vld = 1'b1;
                                n_kind    = swtt_pkg::EV_FIRED;
                                n_sidx    = low4(r_pend_idx);
                                n_last    = 1'b0;
                            end
                            n_pend_vld = 1'b1;
                            n_pend_idx = r_p_idx;
                            n_nfire    = r_nfire + RW'(1);
                        end
                    end else begin
                        w_we    = 1'b1;
                        w_wdata = {w_cur_reload, w_cur_ticks - CW'(1)};
                    end
                end
                if (r_p_vld && (r_p_idx == LAST_SLOT)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (r_pend_vld) begin
                    n_out_vld = 1'b1;
                    n_kind    = swtt_pkg::EV_FIRED;
                    n_sidx    = low4(r_pend_idx);
                    n_last    = 1'b1;
                end
                n_pend_vld = 1'b0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= '0;
            r_periodic   <= '0;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_p_vld      <= 1'b0;
            r_pend_vld   <= 1'b0;
            r_nfire      <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_periodic   <= n_periodic;
            r_idx        <= n_idx;
            r_issue_done <= n_issue_done;
            r_p_vld      <= n_p_vld;
            r_pend_vld   <= n_pend_vld;
            r_nfire      <= n_nfire;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_repeat   <= n_repeat;
        r_period   <= n_period;
        r_p_idx    <= n_p_idx;
        r_pend_idx <= n_pend_idx;
        r_kind     <= n_kind;
        r_sidx     <= n_sidx;
        r_last     <= n_last;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_out_vld;
    assign o_event_kind = r_kind;
    assign o_slot_index = r_sidx;
    assign o_last       = r_last;

    // A table-full report is always the only item of its start.
    a_full_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_event_kind == swtt_pkg::EV_FULL)) |-> o_last)
        else $error("table full report without last");

    // More items follow a non-final one, so the block must still be busy.
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("non-final item while idle");

    // A cancel completes in the cycle it is taken.
    a_cancel_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == swtt_pkg::ACT_CANCEL)) |=> !busy)
        else $error("cancel left the block busy");

    // The update stage only runs during a tick scan.
    a_stage_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld |-> (r_state == S_TICK))
        else $error("update stage active outside a tick scan");

    // The report count never passes the per-tick limit.
    a_report_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfire <= RW'(swtt_pkg::MAX_REPORT))
        else $error("fire report count over limit");

endmodule
